// ----- hw/rtl/igf_pkg.sv -----
// Shared types and constants for the IMU gravity projection and gyro filter.
// No dependencies; imported by igf_div and imu_gravity_and_gyro_filter.
package igf_pkg;

  localparam int QW        = 16;   // quaternion component width
  localparam int RW        = 24;   // gyro rate width
  localparam int AW        = 17;   // smoothing factor width
  localparam int DVD_W     = 50;   // divider dividend width
  localparam int DVS_W     = 34;   // divider divisor width
  localparam int QUO_W     = 17;   // divider quotient width
  localparam int PW        = 43;   // shared multiplier product width

  localparam logic [AW-1:0] ALPHA_ONE = 17'h10000;

  // multiplier op sequence
  localparam logic [3:0] OP_WW = 4'd0;
  localparam logic [3:0] OP_XX = 4'd1;
  localparam logic [3:0] OP_YY = 4'd2;
  localparam logic [3:0] OP_ZZ = 4'd3;
  localparam logic [3:0] OP_YZ = 4'd4;
  localparam logic [3:0] OP_WX = 4'd5;
  localparam logic [3:0] OP_XZ = 4'd6;
  localparam logic [3:0] OP_WY = 4'd7;
  localparam logic [3:0] OP_FX = 4'd8;
  localparam logic [3:0] OP_FY = 4'd9;
  localparam logic [3:0] OP_FZ = 4'd10;
  localparam logic [3:0] OP_LAST = 4'd11;

  // gravity component index
  localparam logic [1:0] G_X = 2'd0;
  localparam logic [1:0] G_Y = 2'd1;
  localparam logic [1:0] G_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_MUL       = 5'b00010,
    ST_DIV_START = 5'b00100,
    ST_DIV_WAIT  = 5'b01000,
    ST_DONE      = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/igf_div.sv -----
// Restoring divider, one quotient bit per cycle, rounding handled by caller.
// Depends on igf_pkg for widths.
module igf_div import igf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output logic               done,
  output logic [QUO_W-1:0]   quot
);

  logic [DVS_W-1:0] rem;
  logic [QUO_W-1:0] dlo;
  logic [DVS_W-1:0] dvs;
  logic [4:0]       cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem, dlo[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dividend[DVD_W-1:QUO_W]};
      dlo  <= dividend[QUO_W-1:0];
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      dlo  <= {dlo[QUO_W-2:0], 1'b0};
      quot <= {quot[QUO_W-2:0], ge};
      if (ge) begin
        rem <= DVS_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DVS_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/imu_gravity_and_gyro_filter.sv -----
// IMU gravity projection and first-order gyro low-pass filter.
// Each input word passes through the shared multiplier (8 quaternion products,
// 3 filter products), then through the bit-serial divider once for each of the
// three gravity components, and is then loaded into the output register.
// A new word is accepted only in idle, once the previous result is loaded.
// Reset (rst, synchronous): filter unprimed, rates zero, smoothing factor 1.0.
module imu_gravity_and_gyro_filter import igf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // gravity_x, gravity_y, gravity_z, rate_x, rate_y, rate_z
  output logic [119:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data
);

  state_t state;
  logic [3:0] cnt;
  logic [3:0] pidx;
  logic [1:0] kdx;

  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [RW-1:0] raw  [3];
  logic signed [RW-1:0] filt [3];
  logic                 primed;
  logic [AW-1:0]        alpha;

  logic signed [24:0]   op_a;
  logic signed [17:0]   op_b;
  logic signed [PW-1:0] p;
  logic [1:0]           fidx;
  logic [1:0]           pf;
  logic signed [24:0]   diff;

  logic [32:0]        n_acc;
  logic signed [33:0] ax, ay, az;

  logic [PW-1:0]        p_mag;
  logic [PW-1:0]        p_rnd;
  logic signed [27:0]   delta;
  logic signed [27:0]   fsum;
  logic signed [RW-1:0] fupd;

  logic signed [33:0] sv;
  logic [33:0]        sv_mag;
  logic [47:0]        mag_sh;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               neg;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   quot;
  logic signed [QW-1:0] gval;
  logic signed [QW-1:0] grav [3];
  logic signed [RW-1:0] rate_z;

  logic in_acc;
  logic out_load;

  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign div_start = (state == ST_DIV_START);
  assign pidx      = cnt - 4'd1;
  assign fidx      = cnt[1:0];
  assign pf        = (pidx[1:0] == 2'd3) ? 2'd0 : pidx[1:0];

  // operand select for the shared multiplier
  always_comb begin
    diff = $signed({raw[(fidx == 2'd3) ? 2'd0 : fidx][RW-1],
                    raw[(fidx == 2'd3) ? 2'd0 : fidx]})
         - $signed({filt[(fidx == 2'd3) ? 2'd0 : fidx][RW-1],
                    filt[(fidx == 2'd3) ? 2'd0 : fidx]});
    case (cnt)
      OP_WW:   begin op_a = 25'(qw); op_b = 18'(qw); end
      OP_XX:   begin op_a = 25'(qx); op_b = 18'(qx); end
      OP_YY:   begin op_a = 25'(qy); op_b = 18'(qy); end
      OP_ZZ:   begin op_a = 25'(qz); op_b = 18'(qz); end
      OP_YZ:   begin op_a = 25'(qy); op_b = 18'(qz); end
      OP_WX:   begin op_a = 25'(qw); op_b = 18'(qx); end
      OP_XZ:   begin op_a = 25'(qx); op_b = 18'(qz); end
      OP_WY:   begin op_a = 25'(qw); op_b = 18'(qy); end
      default: begin op_a = diff;    op_b = $signed({1'b0, alpha}); end
    endcase
  end

  // filter update: prev + round(alpha * (raw - prev) / 2^16)
  always_comb begin
    p_mag = p[PW-1] ? PW'(-p) : PW'(p);
    p_rnd = p_mag + PW'(32768);
    delta = p[PW-1] ? -$signed({1'b0, p_rnd[PW-1:16]}) : $signed({1'b0, p_rnd[PW-1:16]});
    fsum  = 28'(filt[pf]) + delta;
    if (fsum > 28'sd8388607) begin
      fupd = 24'sh7FFFFF;
    end else if (fsum < -28'sd8388608) begin
      fupd = 24'sh800000;
    end else begin
      fupd = fsum[RW-1:0];
    end
  end

  // divider operands for the current gravity component
  always_comb begin
    case (kdx)
      G_X:     begin sv = ax; neg = (ax > 34'sd0); end
      G_Y:     begin sv = ay; neg = (ay > 34'sd0); end
      default: begin sv = az; neg = (az < 34'sd0); end
    endcase
    sv_mag = sv[33] ? 34'(-sv) : 34'(sv);
    if (kdx == G_X) begin
      mag_sh = {1'b0, sv_mag[31:0], 15'b0};
    end else begin
      mag_sh = {sv_mag[31:0], 16'b0};
    end
    dvd = {1'b0, mag_sh, 1'b0} + {17'b0, n_acc};
    dvs = {n_acc, 1'b0};
  end

  always_comb begin
    if (n_acc == 33'd0) begin
      gval = (kdx == G_X) ? 16'sh8000 : 16'sh0000;
    end else if (neg) begin
      gval = 16'(-quot);
    end else if (quot > 17'd32767) begin
      gval = 16'sh7FFF;
    end else begin
      gval = quot[15:0];
    end
  end

  assign rate_z = (filt[0] == 24'sh800000) ? 24'sh7FFFFF : -filt[0];

  igf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      kdx      <= G_X;
      primed   <= 1'b0;
      alpha    <= ALPHA_ONE;
      m_tvalid <= 1'b0;
      filt[0]  <= '0;
      filt[1]  <= '0;
      filt[2]  <= '0;
    end else begin
      if (cfg_valid) begin
        alpha <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cnt   <= '0;
            state <= ST_MUL;
            if (!primed) begin
              primed  <= 1'b1;
              filt[0] <= s_tdata[87:64];
              filt[1] <= s_tdata[111:88];
              filt[2] <= s_tdata[135:112];
            end
          end
        end
        ST_MUL: begin
          cnt <= cnt + 4'd1;
          if (pidx == OP_FX || pidx == OP_FY || pidx == OP_FZ) begin
            filt[pf] <= fupd;
          end
          if (cnt == OP_LAST) begin
            kdx   <= G_X;
            state <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            kdx <= kdx + 2'd1;
            state <= (kdx == G_Z) ? ST_DONE : ST_DIV_START;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qw     <= s_tdata[15:0];
      qx     <= s_tdata[31:16];
      qy     <= s_tdata[47:32];
      qz     <= s_tdata[63:48];
      raw[0] <= s_tdata[87:64];
      raw[1] <= s_tdata[111:88];
      raw[2] <= s_tdata[135:112];
      n_acc  <= '0;
      ax     <= '0;
      ay     <= '0;
      az     <= '0;
    end
    if (state == ST_MUL) begin
      p <= op_a * op_b;
      case (pidx)
        OP_WW: begin n_acc <= n_acc + p[32:0]; ax <= ax + p[33:0]; end
        OP_XX: begin n_acc <= n_acc + p[32:0]; ax <= ax - p[33:0]; end
        OP_YY: begin n_acc <= n_acc + p[32:0]; ax <= ax - p[33:0]; end
        OP_ZZ: begin n_acc <= n_acc + p[32:0]; ax <= ax + p[33:0]; end
        OP_YZ: ay <= ay + p[33:0];
        OP_WX: ay <= ay + p[33:0];
        OP_XZ: az <= az + p[33:0];
        OP_WY: az <= az - p[33:0];
        default: ;
      endcase
    end
    if (state == ST_DIV_WAIT && div_done) begin
      grav[kdx] <= gval;
    end
    if (out_load) begin
      m_tdata <= {rate_z, filt[1], filt[2], grav[2], grav[1], grav[0]};
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_starts_mul: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_MUL) && primed)
    else $error("accepted word did not start the multiply sequence");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= OP_LAST))
    else $error("multiply step count out of range");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && (state == ST_IDLE))
    else $error("result load did not raise valid");
`endif

endmodule
